// ===== design/crcdf_pkg.sv =====
// Shared types, constants and functions of the CRC-checked frame deframer.
// No dependencies; imported by the top level, the controller and the datapath.
package crcdf_pkg;

	localparam int STREAM_BYTES_DEF = 4096;
	localparam int HDR_LEN = 36;
	localparam int PAYLOAD_CAP = 4060;
	localparam logic [31:0] CRC_POLY = 32'hedb88320;
	localparam logic [31:0] CRC_ONES = 32'hffffffff;
	localparam logic [7:0] HDR_LEN_BYTE = 8'd36;

	typedef enum logic [2:0] {
		EV_BUFFERED = 3'd0,
		EV_FRAME    = 3'd1,
		EV_FULL     = 3'd2,
		EV_OVERSIZE = 3'd3,
		EV_PAYLOAD  = 3'd4,
		EV_EMPTY    = 3'd5
	} event_t;

	typedef enum logic [2:0] {
		PRE_READ,
		PRE_BREAK,
		PRE_OVER,
		PRE_PASS,
		PRE_FAIL
	} pre_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE,
		ST_POST,
		ST_POP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic   wr;
		logic   rd_head;
		logic   rd_scan;
		logic   scan_start;
		logic   drop;
		logic   step;
		logic   accept;
		logic   pop_take;
		logic   load_out;
		event_t ev;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic pending;
		pre_t pre;
		logic mismatch;
	} status_t;

	function automatic logic [7:0] sync_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = 8'h41;
			2'd1: b = 8'h53;
			2'd2: b = 8'h44;
			default: b = 8'h4c;
		endcase
		return b;
	endfunction

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

endpackage

// ===== design/crc_checked_frame_deframer_core.sv =====
// CRC-checked frame deframer, top level: controller plus datapath.
// Push to a pending frame and push to a full buffer: IDLE then EMIT; pop: IDLE, POP, then EMIT;
// the result leaves EMIT only when the output register is free. Scan: each byte read passes PRE and POST;
// each dropped head byte restarts the read at offset 0, so a resync re-reads every byte from the new head.
// One item at a time. Reset: buffer empty, no frame pending; buffer contents undefined.
module crc_checked_frame_deframer_core
	import crcdf_pkg::*;
#(
	parameter int STREAM_BYTES = STREAM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_kind,
	output logic [15:0] frame_flags,
	output logic [31:0] seq_number,
	output logic [31:0] packet_size,
	output logic [31:0] frag_offset,
	output logic [11:0] payload_length,
	output logic [15:0] fragment_number,
	output logic [15:0] fragment_total,
	output logic [7:0]  payload_byte,
	output logic        last_payload
);

	cmd_t cmd;
	status_t status;

	crcdf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	crcdf_dpath #(.STREAM_BYTES(STREAM_BYTES)) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.rx_byte         (rx_byte),
		.event_kind      (event_kind),
		.frame_flags     (frame_flags),
		.seq_number      (seq_number),
		.packet_size     (packet_size),
		.frag_offset     (frag_offset),
		.payload_length  (payload_length),
		.fragment_number (fragment_number),
		.fragment_total  (fragment_total),
		.payload_byte    (payload_byte),
		.last_payload    (last_payload)
	);

endmodule

// ===== design/crcdf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module crcdf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/crcdf_ctrl.sv =====
// Controller state machine of the deframer: sequences pushes, pops and the scan.
// Depends on crcdf_pkg.
module crcdf_ctrl
	import crcdf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic    command,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t st_q, st_n;
	logic pop_q, pop_n;
	logic over_q, over_n;
	event_t ev_q, ev_n;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			pop_q <= 1'b0;
			over_q <= 1'b0;
			ev_q <= EV_BUFFERED;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_n;
			pop_q <= pop_n;
			over_q <= over_n;
			ev_q <= ev_n;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		st_n = st_q;
		pop_n = pop_q;
		over_n = over_q;
		ev_n = ev_q;
		cmd = '0;
		cmd.ev = ev_q;
		in_ready = 1'b0;
		case (st_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!command) begin
						if (status.full) begin
							ev_n = EV_FULL;
							st_n = ST_EMIT;
						end else begin
							cmd.wr = 1'b1;
							if (status.pending) begin
								ev_n = EV_BUFFERED;
								st_n = ST_EMIT;
							end else begin
								cmd.scan_start = 1'b1;
								over_n = 1'b0;
								pop_n = 1'b0;
								st_n = ST_PRE;
							end
						end
					end else if (status.pending) begin
						cmd.rd_head = 1'b1;
						st_n = ST_POP;
					end else begin
						cmd.scan_start = 1'b1;
						over_n = 1'b0;
						pop_n = 1'b1;
						st_n = ST_PRE;
					end
				end
			end
			ST_PRE: begin
				case (status.pre)
					PRE_READ: begin
						cmd.rd_scan = 1'b1;
						st_n = ST_POST;
					end
					PRE_OVER: begin
						cmd.drop = 1'b1;
						over_n = 1'b1;
					end
					PRE_PASS: begin
						cmd.accept = 1'b1;
						ev_n = EV_FRAME;
						st_n = ST_EMIT;
					end
					PRE_FAIL: begin
						cmd.drop = 1'b1;
					end
					default: begin
						ev_n = over_q ? EV_OVERSIZE : (pop_q ? EV_EMPTY : EV_BUFFERED);
						st_n = ST_EMIT;
					end
				endcase
			end
			ST_POST: begin
				if (status.mismatch) begin
					cmd.drop = 1'b1;
				end else begin
					cmd.step = 1'b1;
				end
				st_n = ST_PRE;
			end
			ST_POP: begin
				cmd.pop_take = 1'b1;
				ev_n = EV_PAYLOAD;
				st_n = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					st_n = ST_IDLE;
				end
			end
			default: begin
				st_n = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ===== design/crcdf_dpath.sv =====
// Datapath of the deframer: ring buffer, pointers, header shifter, CRC unit, result registers.
// Depends on crcdf_pkg and crcdf_ram.
module crcdf_dpath
	import crcdf_pkg::*;
#(
	parameter int STREAM_BYTES = STREAM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output status_t     status,
	input  logic [7:0]  rx_byte,
	output logic [2:0]  event_kind,
	output logic [15:0] frame_flags,
	output logic [31:0] seq_number,
	output logic [31:0] packet_size,
	output logic [31:0] frag_offset,
	output logic [11:0] payload_length,
	output logic [15:0] fragment_number,
	output logic [15:0] fragment_total,
	output logic [7:0]  payload_byte,
	output logic        last_payload
);

	localparam int AW = $clog2(STREAM_BYTES);
	localparam int FW = $clog2(STREAM_BYTES + 1);
	localparam int LIMIT = (STREAM_BYTES - HDR_LEN < PAYLOAD_CAP) ?
		(STREAM_BYTES - HDR_LEN) : PAYLOAD_CAP;
	localparam logic [AW:0] SDEP = (AW + 1)'(STREAM_BYTES);

	logic [AW-1:0] head_q;
	logic [FW-1:0] fill_q;
	logic pend_q;
	logic [11:0] prem_q;
	logic [FW-1:0] k_q;
	logic [31:0] crc_q, hcrc_q;
	logic [287:0] hdr_q;
	logic [11:0] plen_q;
	logic [15:0] r_flags_q, r_fnum_q, r_ftot_q;
	logic [31:0] r_seq_q, r_size_q, r_off_q;
	logic [11:0] r_plen_q;
	logic [7:0] r_byte_q;
	logic r_last_q;

	logic [AW:0] wsum, rsum, h1, h36;
	logic [AW-1:0] waddr, raddr;
	logic [7:0] rdata, feed;
	logic [31:0] kk, ff, plen_w, hc, pc;
	logic crc_ok;

	always_comb begin
		wsum = {1'b0, head_q} + (AW + 1)'(fill_q);
		if (wsum >= SDEP) wsum = wsum - SDEP;
		rsum = {1'b0, head_q} + (cmd.rd_head ? (AW + 1)'(0) : (AW + 1)'(k_q));
		if (rsum >= SDEP) rsum = rsum - SDEP;
		h1 = {1'b0, head_q} + (AW + 1)'(1);
		if (h1 >= SDEP) h1 = h1 - SDEP;
		h36 = {1'b0, head_q} + (AW + 1)'(HDR_LEN);
		if (h36 >= SDEP) h36 = h36 - SDEP;
	end

	assign waddr = wsum[AW-1:0];
	assign raddr = rsum[AW-1:0];

	crcdf_ram #(.WIDTH(8), .DEPTH(STREAM_BYTES)) u_ram (
		.clk   (clk),
		.we    (cmd.wr),
		.waddr (waddr),
		.wdata (rx_byte),
		.re    (cmd.rd_head | cmd.rd_scan),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign kk = 32'(k_q);
	assign ff = 32'(fill_q);
	assign plen_w = hdr_q[287:256];
	assign hc = (kk == 32'd36) ? ~crc_q : hcrc_q;
	assign pc = (kk == 32'd36) ? 32'd0 : ~crc_q;
	assign crc_ok = (hc == hdr_q[287:256]) && (pc == hdr_q[255:224]);

	always_comb begin
		status.full = ff >= 32'(STREAM_BYTES);
		status.pending = pend_q;
		status.mismatch = ((kk < 32'd4) && (rdata != sync_byte(k_q[1:0]))) ||
			((kk == 32'd5) && (rdata != HDR_LEN_BYTE));
		if ((kk < 32'd4) && (kk >= ff)) begin
			status.pre = PRE_BREAK;
		end else if ((kk == 32'd4) && (ff < 32'd6)) begin
			status.pre = PRE_BREAK;
		end else if ((kk == 32'd6) && (ff < 32'd36)) begin
			status.pre = PRE_BREAK;
		end else if ((kk == 32'd24) && (plen_w > 32'(LIMIT))) begin
			status.pre = PRE_OVER;
		end else if ((kk == 32'd24) && (ff < 32'd36 + 32'(plen_w[11:0]))) begin
			status.pre = PRE_BREAK;
		end else if ((kk >= 32'd36) && (kk == 32'd36 + 32'(plen_q))) begin
			status.pre = crc_ok ? PRE_PASS : PRE_FAIL;
		end else begin
			status.pre = PRE_READ;
		end
	end

	assign feed = ((kk >= 32'd32) && (kk < 32'd36)) ? 8'd0 : rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
			pend_q <= 1'b0;
			prem_q <= '0;
			k_q <= '0;
			crc_q <= CRC_ONES;
		end else begin
			if (cmd.wr) begin
				fill_q <= fill_q + FW'(1);
			end
			if (cmd.scan_start) begin
				k_q <= '0;
				crc_q <= CRC_ONES;
			end
			if (cmd.drop) begin
				head_q <= h1[AW-1:0];
				fill_q <= fill_q - FW'(1);
				k_q <= '0;
				crc_q <= CRC_ONES;
			end
			if (cmd.rd_scan && (kk == 32'd36)) begin
				crc_q <= CRC_ONES;
			end
			if (cmd.step) begin
				k_q <= k_q + FW'(1);
				crc_q <= crc_byte(crc_q, feed);
			end
			if (cmd.accept) begin
				head_q <= h36[AW-1:0];
				fill_q <= fill_q - FW'(HDR_LEN);
				prem_q <= plen_q;
				pend_q <= plen_q != 12'd0;
			end
			if (cmd.pop_take) begin
				head_q <= h1[AW-1:0];
				fill_q <= fill_q - FW'(1);
				prem_q <= prem_q - 12'd1;
				pend_q <= prem_q != 12'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_scan && (kk == 32'd36)) begin
			hcrc_q <= ~crc_q;
		end
		if (cmd.rd_scan && (kk == 32'd24)) begin
			plen_q <= plen_w[11:0];
		end
		if (cmd.step && (kk < 32'd36)) begin
			hdr_q <= {rdata, hdr_q[287:8]};
		end
		if (cmd.accept) begin
			r_flags_q <= hdr_q[63:48];
			r_seq_q <= hdr_q[95:64];
			r_size_q <= hdr_q[127:96];
			r_off_q <= hdr_q[159:128];
			r_plen_q <= plen_q;
			r_fnum_q <= hdr_q[207:192];
			r_ftot_q <= hdr_q[223:208];
		end
		if (cmd.pop_take) begin
			r_byte_q <= rdata;
			r_last_q <= prem_q == 12'd1;
		end
		if (cmd.load_out) begin
			event_kind <= cmd.ev;
			frame_flags <= (cmd.ev == EV_FRAME) ? r_flags_q : '0;
			seq_number <= (cmd.ev == EV_FRAME) ? r_seq_q : '0;
			packet_size <= (cmd.ev == EV_FRAME) ? r_size_q : '0;
			frag_offset <= (cmd.ev == EV_FRAME) ? r_off_q : '0;
			payload_length <= (cmd.ev == EV_FRAME) ? r_plen_q : '0;
			fragment_number <= (cmd.ev == EV_FRAME) ? r_fnum_q : '0;
			fragment_total <= (cmd.ev == EV_FRAME) ? r_ftot_q : '0;
			payload_byte <= (cmd.ev == EV_PAYLOAD) ? r_byte_q : '0;
			last_payload <= (cmd.ev == EV_PAYLOAD) ? r_last_q : 1'b0;
		end
	end

endmodule
